// File: src/dhlf_pkg.sv
// Shared types, codes and constants of the degree histogram line filter.
package dhlf_pkg;

  // Request codes on the text channel
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_END  = 1'b1;

  // Field widths
  localparam int BYTE_W  = 8;
  localparam int RUN_W   = 7;
  localparam int CNT_W   = 11;
  localparam int TOTAL_W = 40;
  localparam int CMP_W   = 17;

  // Saturation limits
  localparam logic [RUN_W-1:0]   RUN_MAX   = {RUN_W{1'b1}};
  localparam logic [CNT_W-1:0]   CNT_MAX   = {CNT_W{1'b1}};
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  // Character codes
  localparam logic [BYTE_W-1:0] CH_NL    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
  localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
  localparam logic [BYTE_W-1:0] CH_LOW_A = 8'h61;
  localparam logic [BYTE_W-1:0] CH_LOW_Z = 8'h7A;

  // Line parser phase, one-hot
  typedef enum logic [4:0] {
    PH_SPACES = 5'b00001,
    PH_DIGITS = 5'b00010,
    PH_ADJ    = 5'b00100,
    PH_DONE   = 5'b01000,
    PH_REJECT = 5'b10000
  } phase_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == CNT_MAX) ? v : v + CNT_W'(1);
  endfunction

  function automatic logic [TOTAL_W-1:0] tot_inc(input logic [TOTAL_W-1:0] v);
    tot_inc = (v == TOTAL_MAX) ? v : v + TOTAL_W'(1);
  endfunction

endpackage

// File: src/dhlf_if.sv
// Valid/ready channel interfaces for text input and line results.
interface dhlf_text_if;
  logic                       valid;
  logic                       ready;
  logic                       op;
  logic [dhlf_pkg::BYTE_W-1:0] text_byte;

  modport source (output valid, output op, output text_byte, input ready);
  modport sink   (input valid, input op, input text_byte, output ready);
endinterface

interface dhlf_result_if;
  logic                        valid;
  logic                        ready;
  logic                        graph_line;
  logic                        large_case;
  logic                        violates;
  logic [dhlf_pkg::TOTAL_W-1:0] total_lines;
  logic [dhlf_pkg::TOTAL_W-1:0] large_lines;
  logic [dhlf_pkg::TOTAL_W-1:0] violation_lines;
  logic                        final_res;

  modport source (output valid, output graph_line, output large_case, output violates,
                  output total_lines, output large_lines, output violation_lines,
                  output final_res, input ready);
  modport sink   (input valid, input graph_line, input large_case, input violates,
                  input total_lines, input large_lines, input violation_lines,
                  input final_res, output ready);
endinterface

// File: src/degree_histogram_line_filter.sv
// Degree histogram line filter: top level with parser, line judge and totals.
//
// Usage:
//   text   : one request per byte (op = byte) or an end-of-input marker (op = end).
//   result : one request per finished line (newline) and one per end marker;
//            bytes inside a line produce nothing.
// Path: a newline or end marker passes the input register, then the result
//   register, where its result waits until result.ready is high.
// Throughput: one request per cycle unless a waiting result stalls; each byte
//   only touches the parser phase, run length and four small per-line counters.
// Reset (rst, synchronous): parser back to line start, per-line counters and
//   the 40-bit running totals cleared, both pipeline registers emptied.
// Stall: while a result waits in the output register and result.ready is low,
//   the input register holds its byte and text.ready drops once it is full;
//   nothing is dropped or duplicated. A result never blocks the intake of
//   further bytes when the receiver keeps ready high.
// Line judging: a graph line is leading spaces, digits, one space, then comma
//   separated letter runs; degrees 3, 5, 6 and 7+ are counted, and a line with
//   three or more high-degree vertices is checked against the weighted test.
module degree_histogram_line_filter (
  input  logic                 clk,
  input  logic                 rst,
  dhlf_text_if.sink            text,
  dhlf_result_if.source        result
);

  // Input register
  logic                          s1_valid;
  logic                          s1_op;
  logic [dhlf_pkg::BYTE_W-1:0]   s1_byte;
  logic                          adv;

  // Parser and per-line state
  dhlf_pkg::phase_t              phase, phase_next;
  logic [dhlf_pkg::RUN_W-1:0]    run_len, run_len_next;
  logic [dhlf_pkg::CNT_W-1:0]    c3, c5, c6, ch;
  logic [dhlf_pkg::CNT_W-1:0]    c3_b, c5_b, c6_b, ch_b;
  logic [dhlf_pkg::TOTAL_W-1:0]  total_count, large_count, violation_count;
  logic [dhlf_pkg::TOTAL_W-1:0]  total_next, large_next, viol_next;

  // Output register
  logic                          out_valid;

  logic is_digit, is_lower, is_space, is_comma, is_nl;
  logic finish, step, do_bin;
  logic graph, large_hit, viol;
  logic [dhlf_pkg::CMP_W-1:0] lhs, rhs;

  // Stage handshake: the input register moves on when the result slot is free
  assign adv        = s1_valid && (!out_valid || result.ready);
  assign text.ready = !s1_valid || adv;
  assign result.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (text.ready) begin
      s1_valid <= text.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (text.ready && text.valid) begin
      s1_op   <= text.op;
      s1_byte <= text.text_byte;
    end
  end

  // Byte classes
  assign is_digit = (s1_byte >= dhlf_pkg::CH_ZERO) && (s1_byte <= dhlf_pkg::CH_NINE);
  assign is_lower = (s1_byte >= dhlf_pkg::CH_LOW_A) && (s1_byte <= dhlf_pkg::CH_LOW_Z);
  assign is_space = (s1_byte == dhlf_pkg::CH_SPACE);
  assign is_comma = (s1_byte == dhlf_pkg::CH_COMMA);
  assign is_nl    = (s1_byte == dhlf_pkg::CH_NL);

  assign finish = adv && ((s1_op == dhlf_pkg::OP_END) || is_nl);
  assign step   = adv && !finish;
  // A letter run closes at a non-letter byte or at the end of the line
  assign do_bin = adv && (phase == dhlf_pkg::PH_ADJ) && (run_len != '0) &&
                  (finish || !is_lower);

  // Degree binning of the closing run; other lengths count nowhere
  always_comb begin
    c3_b = c3;
    c5_b = c5;
    c6_b = c6;
    ch_b = ch;
    if (do_bin) begin
      if (run_len == dhlf_pkg::RUN_W'(3)) begin
        c3_b = dhlf_pkg::sat_inc(c3);
      end else if (run_len == dhlf_pkg::RUN_W'(5)) begin
        c5_b = dhlf_pkg::sat_inc(c5);
      end else if (run_len == dhlf_pkg::RUN_W'(6)) begin
        c6_b = dhlf_pkg::sat_inc(c6);
      end else if (run_len >= dhlf_pkg::RUN_W'(7)) begin
        ch_b = dhlf_pkg::sat_inc(ch);
      end
    end
  end

  // Line judgment: 20*p6 < 39 + 10*p3 - 5*p5 - 20*S, rearranged to stay unsigned
  assign lhs = dhlf_pkg::CMP_W'(c6_b) * dhlf_pkg::CMP_W'(20)
             + dhlf_pkg::CMP_W'(c5_b) * dhlf_pkg::CMP_W'(5)
             + dhlf_pkg::CMP_W'(ch_b) * dhlf_pkg::CMP_W'(20);
  assign rhs = dhlf_pkg::CMP_W'(39) + dhlf_pkg::CMP_W'(c3_b) * dhlf_pkg::CMP_W'(10);

  assign graph     = (phase == dhlf_pkg::PH_ADJ) || (phase == dhlf_pkg::PH_DONE);
  assign large_hit = graph && (ch_b >= dhlf_pkg::CNT_W'(3));
  assign viol      = large_hit && (lhs < rhs);

  always_comb begin
    total_next = total_count;
    large_next = large_count;
    viol_next  = violation_count;
    if (finish && graph) begin
      total_next = dhlf_pkg::tot_inc(total_count);
    end
    if (finish && large_hit) begin
      large_next = dhlf_pkg::tot_inc(large_count);
    end
    if (finish && viol) begin
      viol_next = dhlf_pkg::tot_inc(violation_count);
    end
  end

  // Parser phase and run length
  always_comb begin
    phase_next   = phase;
    run_len_next = run_len;
    if (finish) begin
      phase_next   = dhlf_pkg::PH_SPACES;
      run_len_next = '0;
    end else if (step) begin
      unique case (phase)
        dhlf_pkg::PH_SPACES: begin
          if (!is_space) begin
            phase_next = is_digit ? dhlf_pkg::PH_DIGITS : dhlf_pkg::PH_REJECT;
          end
        end
        dhlf_pkg::PH_DIGITS: begin
          if (!is_digit) begin
            phase_next = is_space ? dhlf_pkg::PH_ADJ : dhlf_pkg::PH_REJECT;
          end
        end
        dhlf_pkg::PH_ADJ: begin
          if (is_lower) begin
            if (run_len != dhlf_pkg::RUN_MAX) begin
              run_len_next = run_len + dhlf_pkg::RUN_W'(1);
            end
          end else begin
            run_len_next = '0;
            if (!is_comma) begin
              phase_next = dhlf_pkg::PH_DONE;
            end
          end
        end
        default: begin
          phase_next = phase;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= dhlf_pkg::PH_SPACES;
      run_len         <= '0;
      c3              <= '0;
      c5              <= '0;
      c6              <= '0;
      ch              <= '0;
      total_count     <= '0;
      large_count     <= '0;
      violation_count <= '0;
    end else begin
      phase           <= phase_next;
      run_len         <= run_len_next;
      total_count     <= total_next;
      large_count     <= large_next;
      violation_count <= viol_next;
      if (finish) begin
        c3 <= '0;
        c5 <= '0;
        c6 <= '0;
        ch <= '0;
      end else begin
        c3 <= c3_b;
        c5 <= c5_b;
        c6 <= c6_b;
        ch <= ch_b;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      result.graph_line      <= graph;
      result.large_case      <= large_hit;
      result.violates        <= viol;
      result.total_lines     <= total_next;
      result.large_lines     <= large_next;
      result.violation_lines <= viol_next;
      result.final_res       <= (s1_op == dhlf_pkg::OP_END);
    end
  end

  // Checks
  a_ready_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !text.ready |-> s1_valid)
    else $error("input stalled while input register empty");

  a_flag_nesting: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((!result.violates || result.large_case) &&
                   (!result.large_case || result.graph_line)))
    else $error("result flags not nested");

  a_totals_ordered: assert property (@(posedge clk) disable iff (rst)
    (large_count <= total_count) && (violation_count <= large_count))
    else $error("running totals out of order");

  a_totals_monotonic: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (total_count >= $past(total_count)))
    else $error("graph line total decreased");

  a_clean_line_start: assert property (@(posedge clk) disable iff (rst)
    (phase == dhlf_pkg::PH_SPACES) |->
      (run_len == '0 && c3 == '0 && c5 == '0 && c6 == '0 && ch == '0))
    else $error("per-line state not cleared at line start");

endmodule
